@@ rtl/b64enc_pkg.sv @@
package b64enc_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // Number of '=' characters that close a group.
    typedef enum logic [1:0] {
        PADS_NONE = 2'd0,
        PADS_ONE  = 2'd1,
        PADS_TWO  = 2'd2
    } pads_t;

    // Position of a character within its group of four.
    typedef enum logic [1:0] {
        CHAR_0 = 2'd0,
        CHAR_1 = 2'd1,
        CHAR_2 = 2'd2,
        CHAR_3 = 2'd3
    } char_idx_t;

    typedef enum logic [1:0] {
        PHASE_EMPTY = 2'd0,
        PHASE_ONE   = 2'd1,
        PHASE_TWO   = 2'd2
    } phase_t;

    // One group of three bytes, first byte in the top bits.
    typedef struct packed {
        logic [23:0] word;
        pads_t       pads;
        logic        last;
    } group_t;

    // Alphabet lookup for one sextet.
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] w;
        w = {1'b0, v};
        if (v < 6'd26) begin
            b64_char = 7'h41 + w;
        end else if (v < 6'd52) begin
            b64_char = 7'h61 + (w - 7'd26);
        end else if (v < 6'd62) begin
            b64_char = 7'h30 + (w - 7'd52);
        end else if (v == 6'd62) begin
            b64_char = 7'h2B;
        end else begin
            b64_char = 7'h2F;
        end
    endfunction

endpackage

@@ rtl/base64_stream_encoder.sv @@
// Order: the beat that completes a group writes it into the group queue; its first character
// is then registered on the master side, and the others follow one per cycle when taken.
// Throughput: one byte beat per cycle until the group queue fills; the character unit emits
// one character per cycle while the downstream side takes beats.
// Reset: aresetn is synchronous and active low; it empties the queue, clears the group phase
// and drops m_tvalid. The pending bytes hold no reset value.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Byte input.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte: last byte of the message
    // Character output.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast,   // run_last: fourth character of a group
    output logic [0:0] m_tuser    // [0] message_end
);

    // The front gathers bytes into groups of three and decides the padding. A finished
    // group goes into a short queue, so the front can keep taking beats while the back
    // unit is still spelling out an earlier group.
    b64enc_pkg::group_t push_group;
    b64enc_pkg::group_t q_head;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_not_empty;
    logic               msg_end;

    b64enc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_final   (s_tlast),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_group (push_group)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // The back unit steps through the four sextets of the head group, one per cycle while the
    // output register can advance: when it is empty or the downstream side takes a beat.
    b64enc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_last    (m_tlast),
        .out_end     (msg_end)
    );

    assign m_tuser = msg_end;

endmodule

@@ rtl/b64enc_front.sv @@
module b64enc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  in_final,
    input  logic                  q_full,
    output logic                  in_ready,
    output logic                  push,
    output b64enc_pkg::group_t    push_group
);

    b64enc_pkg::phase_t phase_reg, phase_next;
    logic [7:0]         p0_reg, p0_next;
    logic [7:0]         p1_reg, p1_next;
    logic               accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= b64enc_pkg::PHASE_EMPTY;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
    end

    always_comb begin
        phase_next      = phase_reg;
        p0_next         = p0_reg;
        p1_next         = p1_reg;
        push            = 1'b0;
        push_group.word = {p0_reg, p1_reg, in_byte};
        push_group.pads = b64enc_pkg::PADS_NONE;
        push_group.last = in_final;
        if (accept) begin
            unique case (phase_reg)
                b64enc_pkg::PHASE_ONE: begin
                    if (in_final) begin
                        push            = 1'b1;
                        push_group.word = {p0_reg, in_byte, 8'h00};
                        push_group.pads = b64enc_pkg::PADS_ONE;
                        phase_next      = b64enc_pkg::PHASE_EMPTY;
                    end else begin
                        p1_next    = in_byte;
                        phase_next = b64enc_pkg::PHASE_TWO;
                    end
                end
                b64enc_pkg::PHASE_TWO: begin
                    push       = 1'b1;
                    phase_next = b64enc_pkg::PHASE_EMPTY;
                end
                default: begin
                    if (in_final) begin
                        push            = 1'b1;
                        push_group.word = {in_byte, 16'h0000};
                        push_group.pads = b64enc_pkg::PADS_TWO;
                        phase_next      = b64enc_pkg::PHASE_EMPTY;
                    end else begin
                        p0_next    = in_byte;
                        phase_next = b64enc_pkg::PHASE_ONE;
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/b64enc_queue.sv @@
module b64enc_queue #(
    parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  b64enc_pkg::group_t push_group,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output b64enc_pkg::group_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64enc_pkg::group_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_group;
        end
    end

endmodule

@@ rtl/b64enc_back.sv @@
module b64enc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  b64enc_pkg::group_t q_head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_data,
    output logic               out_last,
    output logic               out_end
);

    b64enc_pkg::char_idx_t idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic [6:0]            char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  end_reg, end_next;
    logic                  load;
    logic [5:0]            sextet;
    logic                  is_pad;

    assign load = q_not_empty && (!valid_reg || out_ready);
    assign pop  = load && (idx_reg == b64enc_pkg::CHAR_3);

    always_comb begin
        unique case (idx_reg)
            b64enc_pkg::CHAR_0: sextet = q_head.word[23:18];
            b64enc_pkg::CHAR_1: sextet = q_head.word[17:12];
            b64enc_pkg::CHAR_2: sextet = q_head.word[11:6];
            default:            sextet = q_head.word[5:0];
        endcase
        is_pad = ((idx_reg == b64enc_pkg::CHAR_3) && (q_head.pads != b64enc_pkg::PADS_NONE))
              || ((idx_reg == b64enc_pkg::CHAR_2) && (q_head.pads == b64enc_pkg::PADS_TWO));
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        end_next   = end_reg;
        if (load) begin
            valid_next = 1'b1;
            char_next  = is_pad ? b64enc_pkg::PAD_CHAR : b64enc_pkg::b64_char(sextet);
            last_next  = (idx_reg == b64enc_pkg::CHAR_3);
            end_next   = (idx_reg == b64enc_pkg::CHAR_3) && q_head.last;
            idx_next   = b64enc_pkg::char_idx_t'(idx_reg + 2'd1);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= b64enc_pkg::CHAR_0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = {1'b0, char_reg};
    assign out_last  = last_reg;
    assign out_end   = end_reg;

endmodule

@@ rtl/b64enc_checker.sv @@
module b64enc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // A stalled character beat keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled output beat changed");

    // The end of the message is always the last character of a group.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("message end without group end");

    // Every character is from the alphabet or the pad.
    a_alphabet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >= 8'h41 && m_tdata <= 8'h5A)
            || (m_tdata >= 8'h61 && m_tdata <= 8'h7A)
            || (m_tdata >= 8'h30 && m_tdata <= 8'h39)
            || m_tdata == 8'h2B || m_tdata == 8'h2F || m_tdata == 8'h3D)
        else $error("character outside the alphabet");

    // Reset drops the output valid.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

@@ tb/tb_top.sv @@
module tb_top;

    import b64enc_pkg::*;

    // Run-time ceiling, in time units: far above the slowest legal run.
    localparam int RUN_LIMIT    = 400000;
    localparam int DIR_ROWS     = 23;
    localparam int RANDOM_BYTES = 285;
    localparam int TAIL_CYCLES  = 40;

    // Standard alphabet, first character in the top byte.
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One expected character beat on the master side.
    typedef struct packed {
        logic [6:0] code;
        logic       run_last;
        logic       msg_end;
    } exp_char_t;

    // One directed beat; chars is zero where the encoder model supplies the answer.
    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic [31:0] chars;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    exp_char_t  char_q[$];
    int         err_count = 0;
    int         rx_stall  = 0;
    int         rx_free   = 0;

    // Encoder model state.
    phase_t     enc_phase;
    logic [7:0] held_byte0;
    logic [7:0] held_byte1;

    dir_row_t   dir_rows [DIR_ROWS];

    base64_stream_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Period of four time units.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Hard stop, should the design hang.
    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic logic [6:0] sextet_ascii(input logic [5:0] v);
        logic [7:0] c;
        c = ALPHABET[8*(63 - int'(v)) +: 8];
        return c[6:0];
    endfunction

    // Works out the four characters a group of bytes turns into, pads applied.
    function automatic logic [27:0] group_chars(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c, input pads_t pads);
        logic [6:0] ch0, ch1, ch2, ch3;
        ch0 = sextet_ascii(a[7:2]);
        ch1 = sextet_ascii({a[1:0], b[7:4]});
        ch2 = sextet_ascii({b[3:0], c[7:6]});
        ch3 = sextet_ascii(c[5:0]);
        if (pads != PADS_NONE) ch3 = PAD_CHAR;
        if (pads == PADS_TWO) ch2 = PAD_CHAR;
        return {ch0, ch1, ch2, ch3};
    endfunction

    // Advances the encoder model by one accepted byte. Returns 1 when the byte closes
    // a group, with the four characters in chars (first character in the top bits).
    function automatic bit model_take_byte(input logic [7:0] d, input logic fin,
                                           output logic [27:0] chars);
        chars = '0;
        case (enc_phase)
            PHASE_ONE: begin
                if (!fin) begin
                    held_byte1 = d;
                    enc_phase  = PHASE_TWO;
                    return 1'b0;
                end
                // Two real bytes: one pad character.
                enc_phase = PHASE_EMPTY;
                chars     = group_chars(held_byte0, d, 8'h00, PADS_ONE);
                return 1'b1;
            end
            PHASE_TWO: begin
                // Full group; a final flag here means no padding at all.
                enc_phase = PHASE_EMPTY;
                chars     = group_chars(held_byte0, held_byte1, d, PADS_NONE);
                return 1'b1;
            end
            default: begin
                // An out-of-range phase behaves as the start of a group.
                if (!fin) begin
                    held_byte0 = d;
                    enc_phase  = PHASE_ONE;
                    return 1'b0;
                end
                // A lone final byte: two pad characters.
                enc_phase = PHASE_EMPTY;
                chars     = group_chars(d, 8'h00, 8'h00, PADS_TWO);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic queue_group(input logic [27:0] chars, input logic fin);
        exp_char_t e;
        for (int k = 0; k < 4; k++) begin
            e.code     = chars[27 - 7*k -: 7];
            e.run_last = (k == 3);
            e.msg_end  = (k == 3) && fin;
            char_q     = {char_q, e};
        end
    endtask

    // Drives one byte beat after a gap and waits for it to be taken. The expectation is
    // queued at the accepting edge; a non-zero typed value replaces the model's answer.
    task automatic send_byte(input logic [7:0] d, input logic fin, input logic [31:0] typed,
                             input int gap);
        logic [27:0] chars;
        bit          closes;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        closes = model_take_byte(d, fin, chars);
        if (typed != '0) begin
            queue_group({typed[30:24], typed[22:16], typed[14:8], typed[6:0]}, fin);
        end else if (closes) begin
            queue_group(chars, fin);
        end
    endtask

    // Holds the byte side idle until every character owed has been taken.
    task automatic drain_pause();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (char_q.size() != 0) @(negedge aclk);
    endtask

    // The receiver stalls for a drawn number of cycles after each beat, with runs of
    // back-to-back acceptance mixed in.
    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: every accepted character beat is matched against the oldest
    // expectation, field by field, including the unused top bit of tdata.
    always @(posedge aclk) begin : char_check
        exp_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (char_q.size() == 0) begin
                report("character with none expected", int'(m_tdata), 0);
            end else begin
                want = char_q.pop_front();
                if (m_tdata[6:0] !== want.code)
                    report("out_char", int'(m_tdata[6:0]), int'(want.code));
                if (m_tdata[7] !== 1'b0)
                    report("tdata top bit", int'(m_tdata[7]), 0);
                if (m_tlast !== want.run_last)
                    report("run_last", int'(m_tlast), int'(want.run_last));
                if (m_tuser[0] !== want.msg_end)
                    report("message_end", int'(m_tuser[0]), int'(want.msg_end));
            end
            if (rx_free > 0) begin
                rx_free--;
                rx_stall = 0;
            end else if ($urandom_range(0, 4) == 0) begin
                rx_free  = $urandom_range(8, 30);
                rx_stall = 0;
            end else begin
                rx_stall = $urandom_range(0, 17);
            end
        end
    end

    initial begin : stimulus
        int sent;
        int msg_len;
        int gap;
        bit no_gaps;
        bit paused;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;

        enc_phase  = PHASE_EMPTY;
        held_byte0 = '0;
        held_byte1 = '0;

        // Directed beats: lone bytes, pairs and full groups at both extremes, a final
        // flag on the third byte of a group, and the characters at the alphabet's top end.
        dir_rows = '{
            '{8'h00, 1'b1, "AA=="},
            '{8'hFF, 1'b1, "/w=="},
            '{8'h00, 1'b0, 32'h0},
            '{8'h00, 1'b1, "AAA="},
            '{8'hFF, 1'b0, 32'h0},
            '{8'hFF, 1'b1, "//8="},
            '{8'h00, 1'b0, 32'h0},
            '{8'h00, 1'b0, 32'h0},
            '{8'h00, 1'b0, "AAAA"},
            '{8'hFF, 1'b0, 32'h0},
            '{8'hFF, 1'b0, 32'h0},
            '{8'hFF, 1'b1, "////"},
            '{8'h4D, 1'b0, 32'h0},
            '{8'h61, 1'b0, 32'h0},
            '{8'h6E, 1'b0, "TWFu"},
            '{8'hFB, 1'b0, 32'h0},
            '{8'hEF, 1'b0, 32'h0},
            '{8'hBE, 1'b1, "++++"},
            '{8'h80, 1'b0, 32'h0},
            '{8'h01, 1'b0, 32'h0},
            '{8'h7F, 1'b0, 32'h0},
            '{8'h55, 1'b0, 32'h0},
            '{8'hAA, 1'b1, 32'h0}
        };

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].chars,
                      $urandom_range(0, 17));
        end
        drain_pause();

        // Random messages: mostly short, now and then a long one; some sent with no gaps.
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0) msg_len = $urandom_range(10, 30);
            else                           msg_len = $urandom_range(1, 9);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < msg_len; j++) begin
                gap = no_gaps ? 0 : $urandom_range(0, 17);
                send_byte(8'($urandom_range(0, 255)), (j == msg_len - 1), 32'h0, gap);
            end
            sent += msg_len;
            if (!paused && sent > RANDOM_BYTES / 2) begin
                drain_pause();
                paused = 1'b1;
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (char_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_queue.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder.sv
rtl/b64enc_checker.sv
tb/tb_top.sv
